/* hdl/slfp_pkg.sv */
// Shared types and constants for the sound-level frame parser.
package slfp_pkg;

  // Header bytes of a level frame.
  localparam logic [7:0] StartByte0   = 8'hBB;
  localparam logic [7:0] StartByte1   = 8'hAA;
  localparam logic [7:0] LevelCommand = 8'h01;

  // Number of bytes in one frame.
  localparam int unsigned FrameBytes = 6;

  // Width of the frame position, enough to count the frame bytes.
  localparam int unsigned PosWidth = $clog2(FrameBytes);

  // Position of the byte now expected within a frame.
  typedef enum logic [PosWidth-1:0] {
    PosStart0 = 3'd0,
    PosStart1 = 3'd1,
    PosCmd    = 3'd2,
    PosLow    = 3'd3,
    PosHigh   = 3'd4,
    PosSum    = 3'd5
  } slfp_pos_e;

  // Outcome of parsing one byte.
  typedef struct packed {
    logic [PosWidth-1:0] position;
    logic                good;
    logic [15:0]         level;
  } slfp_result_t;

endpackage

/* hdl/sound_level_frame_parser.sv */
// Sound-level sensor frame parser top level: input register, parser, result register.
//
// Usage: bytes from the sensor link enter on in_valid_i / rx_byte_i and are taken at an
// edge where in_valid_i is high and in_stall_o is low. Each byte gives exactly one result
// item on out_valid_o with frame_position_o, frame_good_o and level_tenths_db_o, taken at
// an edge where out_valid_o is high and out_stall_i is low.
// The parser hunts for frames BB AA 01 lo hi sum; a frame whose additive checksum matches
// loads the held level (tenths of a dB, little-endian), a bad one is dropped.
// Path: a taken byte sits in the input register and is parsed into the result register once
// that register is free. Throughput: one byte per cycle while the receiver does not stall;
// the parser state updates as each byte moves between the two registers.
// Stalling: while the receiver stalls, the result register holds its item and the input
// register can still take one more byte; only when both are full is in_stall_o raised.
// Reset: rst_ni clears both valid flags, the frame position, the running sum and the
// held level to zero.
module sound_level_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  frame_position_o,
  output logic        frame_good_o,
  output logic [15:0] level_tenths_db_o
);
  import slfp_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  slfp_result_t out_q;
  slfp_result_t result;
  logic         out_free;
  logic         advance;
  logic         in_take;

  // Handshake between the two stages.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Parser state updates once per byte moved into the result register.
  slfp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .result_o  (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_position_o  = out_q.position;
  assign frame_good_o      = out_q.good;
  assign level_tenths_db_o = out_q.level;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with a free stage");
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("parsed item lost");
  a_good_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.good |-> out_q.position == PosStart0)
    else $error("good frame did not return to start");
`endif

endmodule

/* hdl/slfp_parser.sv */
// Frame parser state: position, running checksum, level bytes and held level.
module slfp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          rx_byte_i,
  output slfp_pkg::slfp_result_t result_o
);
  import slfp_pkg::*;

  slfp_pos_e   pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  low_q, high_q;
  logic [15:0] level_q, level_d;
  logic        mismatch;
  logic        good;

  // Header check and checksum compare for the byte at the current position.
  always_comb begin
    mismatch = 1'b0;
    good     = 1'b0;
    level_d  = level_q;
    unique case (pos_q)
      PosStart0: mismatch = (rx_byte_i != StartByte0);
      PosStart1: mismatch = (rx_byte_i != StartByte1);
      PosCmd:    mismatch = (rx_byte_i != LevelCommand);
      PosLow:    mismatch = 1'b0;
      PosHigh:   mismatch = 1'b0;
      PosSum: begin
        if (sum_q == rx_byte_i) begin
          good    = 1'b1;
          level_d = {high_q, low_q};
        end
      end
      default:   mismatch = 1'b1;
    endcase
  end

  // Next position and running sum.
  always_comb begin
    if (mismatch) begin
      pos_d = PosStart0;
      sum_d = 8'd0;
    end else if (pos_q == PosSum) begin
      pos_d = PosStart0;
      sum_d = 8'd0;
    end else begin
      pos_d = slfp_pos_e'(pos_q + 3'd1);
      sum_d = (pos_q == PosStart0) ? rx_byte_i : 8'(sum_q + rx_byte_i);
    end
  end

  // Control state and held level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosStart0;
      sum_q   <= 8'd0;
      level_q <= 16'd0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      level_q <= level_d;
    end
  end

  // Level bytes of the frame in flight; always written before they are used.
  always_ff @(posedge clk_i) begin
    if (step_i && pos_q == PosLow) begin
      low_q <= rx_byte_i;
    end
    if (step_i && pos_q == PosHigh) begin
      high_q <= rx_byte_i;
    end
  end

  assign result_o.position = pos_d;
  assign result_o.good     = good;
  assign result_o.level    = level_d;

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosSum)
    else $error("frame position out of range");
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(pos_q) && $stable(sum_q) && $stable(level_q))
    else $error("parser state moved without a byte");
  a_bad_sum_keeps_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && pos_q == PosSum && sum_q != rx_byte_i |=> $stable(level_q) && pos_q == PosStart0)
    else $error("bad checksum changed the held level");
`endif

endmodule

/* verif/tb_sound_level_frame_parser.sv */
// Self-checking testbench for the sound-level frame parser, with a frame-level predictor.
module tb_sound_level_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import slfp_pkg::*;

  localparam int unsigned ClkHalfNs     = 5;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned IdlePercent   = 31;
  localparam int unsigned RandomItems   = 550;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned TimeoutNs     = 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  frame_position_o;
  logic        frame_good_o;
  logic [15:0] level_tenths_db_o;

  // Chance in a hundred that either side idles in a given cycle.
  int unsigned idle_pct = IdlePercent;
  int unsigned bytes_sent = 0;
  int unsigned fail_count = 0;

  // Parser outcomes still owed by the block, oldest first.
  slfp_result_t pending_outcomes[$];

  // Predictor copy of the parser state.
  slfp_pos_e   pred_pos = PosStart0;
  logic [7:0]  pred_sum = 8'h00;
  logic [7:0]  pred_low = 8'h00;
  logic [7:0]  pred_high = 8'h00;
  logic [15:0] pred_level = 16'h0000;

  sound_level_frame_parser u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_position_o (frame_position_o),
    .frame_good_o     (frame_good_o),
    .level_tenths_db_o(level_tenths_db_o)
  );

  // Free-running clock.
  always begin
    #ClkHalfNs clk_i = 1'b1;
    #ClkHalfNs clk_i = 1'b0;
  end

  // Receiver stalls at random while idling is enabled.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  // Work out the outcome of every byte the block takes.
  always @(posedge clk_i) begin : parse_predictor
    logic         hdr_broken;
    logic         sum_ok;
    logic [7:0]   b;
    slfp_result_t outcome;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      b = rx_byte_i;
      hdr_broken = 1'b0;
      sum_ok = 1'b0;
      case (pred_pos)
        PosStart0: hdr_broken = (b != StartByte0);
        PosStart1: hdr_broken = (b != StartByte1);
        PosCmd:    hdr_broken = (b != LevelCommand);
        PosLow:    pred_low = b;
        PosHigh:   pred_high = b;
        PosSum: begin
          if (pred_sum == b) begin
            pred_level = {pred_high, pred_low};
            sum_ok = 1'b1;
          end
        end
        default:   hdr_broken = 1'b1;
      endcase
      if (hdr_broken) begin
        pred_pos = PosStart0;
        pred_sum = 8'h00;
      end else if (pred_pos == PosSum) begin
        // The sum byte closes the frame whatever its value.
        pred_pos = PosStart0;
        pred_sum = 8'h00;
      end else begin
        pred_sum = (pred_pos == PosStart0) ? b : pred_sum + b;
        pred_pos = slfp_pos_e'(pred_pos + 3'd1);
      end
      outcome.position = pred_pos;
      outcome.good     = sum_ok;
      outcome.level    = pred_level;
      pending_outcomes.push_back(outcome);
    end
  end

  // Compare each result item with the oldest outstanding outcome.
  always @(posedge clk_i) begin : outcome_checker
    slfp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        $error("result item with no byte outstanding: position %0d good %0d level %0d",
               frame_position_o, frame_good_o, level_tenths_db_o);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (frame_position_o !== want.position) begin
          $error("frame_position: expected %0d, got %0d", want.position, frame_position_o);
          fail_count++;
        end
        if (frame_good_o !== want.good) begin
          $error("frame_good: expected %0d, got %0d", want.good, frame_good_o);
          fail_count++;
        end
        if (level_tenths_db_o !== want.level) begin
          $error("level_tenths_db: expected %0d, got %0d", want.level, level_tenths_db_o);
          fail_count++;
        end
      end
    end
  end

  // Offer one byte, with a random idle gap first, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // Send a complete level frame; a non-zero spoil value corrupts the checksum.
  task automatic send_frame(input logic [7:0] lo, input logic [7:0] hi,
                            input logic [7:0] spoil);
    logic [7:0] chk;
    chk = StartByte0 + StartByte1 + LevelCommand + lo + hi;
    send_byte(StartByte0);
    send_byte(StartByte1);
    send_byte(LevelCommand);
    send_byte(lo);
    send_byte(hi);
    send_byte(chk ^ spoil);
  endtask

  // Pick a level byte, leaning towards the extremes now and then.
  function automatic logic [7:0] pick_level_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Good frames at the lowest and highest levels.
  task automatic test_good_frames();
    send_frame(8'h00, 8'h00, 8'h00);
    send_frame(8'hFF, 8'hFF, 8'h00);
  endtask

  // A frame with a wrong checksum must leave the held level alone.
  task automatic test_bad_checksum();
    send_frame(8'h34, 8'h12, 8'h80);
  endtask

  // Version command and a repeated start byte both break the header.
  task automatic test_header_mismatch();
    send_byte(StartByte0);
    send_byte(StartByte1);
    send_byte(8'h00);
    // The second start byte is not taken as a fresh start.
    send_byte(StartByte0);
    send_byte(StartByte0);
    send_byte(StartByte1);
    send_byte(LevelCommand);
  endtask

  // Mostly well-formed frames with random content, plus broken ones and noise.
  task automatic test_random_stream();
    int unsigned start_count;
    int unsigned kind;
    int unsigned cut;
    int unsigned n;
    logic [7:0]  wrong;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RandomItems) begin
      // A long stretch in the middle runs with neither side idling.
      if (bytes_sent - start_count >= 200 && bytes_sent - start_count < 330) begin
        idle_pct = 0;
      end else begin
        idle_pct = IdlePercent;
      end
      kind = $urandom_range(9);
      if (kind <= 5) begin
        send_frame(pick_level_byte(), pick_level_byte(), 8'h00);
      end else if (kind == 6) begin
        send_frame(pick_level_byte(), pick_level_byte(), 8'($urandom_range(1, 255)));
      end else if (kind == 7) begin
        // Header broken at the second or third byte.
        cut = $urandom_range(1, 2);
        send_byte(StartByte0);
        if (cut == 2) begin
          send_byte(StartByte1);
        end
        do begin
          wrong = ($urandom_range(3) == 0) ? StartByte0 : 8'($urandom_range(255));
        end while (wrong == ((cut == 1) ? StartByte1 : LevelCommand));
        send_byte(wrong);
      end else if (kind == 8) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(255)));
      end else begin
        // Version frame followed by its payload bytes.
        send_byte(StartByte0);
        send_byte(StartByte1);
        send_byte(8'h00);
        repeat (3) send_byte(8'($urandom_range(255)));
      end
    end
    idle_pct = IdlePercent;
  endtask

  // Main sequence.
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_good_frames();
    test_bad_checksum();
    test_header_mismatch();
    test_random_stream();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TimeoutNs * 1ns);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sound_level_frame_parser.f */
hdl/slfp_pkg.sv
hdl/slfp_parser.sv
hdl/sound_level_frame_parser.sv
verif/tb_sound_level_frame_parser.sv
